[hw/rtl/elg_pkg.sv]
// ----------------------------------------------------------------------------
// elg_pkg: shared types and constants of the ElGamal byte cipher
// Payload structs of both transfer directions, register map, reset values.
// ----------------------------------------------------------------------------
package elg_pkg;

  // Default width of the modular datapath
  localparam int unsigned MOD_WIDTH_DEF = 16;

  // Fixed widths of the register and item fields
  localparam int unsigned CFG_WIDTH   = 16;
  localparam int unsigned FIELD_WIDTH = 16;
  localparam int unsigned BYTE_WIDTH  = 8;

  // APB register map: register i at byte address 4*i
  localparam int unsigned ADDR_WIDTH = 4;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_WIDTH  = 2;

  localparam logic [IDX_WIDTH-1:0] REG_PRIME_MODULUS = 2'd0;
  localparam logic [IDX_WIDTH-1:0] REG_GENERATOR     = 2'd1;
  localparam logic [IDX_WIDTH-1:0] REG_PRIVATE_KEY   = 2'd2;

  localparam logic [CFG_WIDTH-1:0] PRIME_MODULUS_RST = 16'd593;
  localparam logic [CFG_WIDTH-1:0] GENERATOR_RST     = 16'd123;
  localparam logic [CFG_WIDTH-1:0] PRIVATE_KEY_RST   = 16'd8;

  // Operation codes
  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  typedef struct packed {
    logic                   mode;
    logic [BYTE_WIDTH-1:0]  message_byte;
    logic [FIELD_WIDTH-1:0] nonce;
    logic [FIELD_WIDTH-1:0] cipher_first;
    logic [FIELD_WIDTH-1:0] cipher_second;
  } in_item_t;

  typedef struct packed {
    logic                   result_mode;
    logic [FIELD_WIDTH-1:0] out_first;
    logic [FIELD_WIDTH-1:0] out_second;
    logic [BYTE_WIDTH-1:0]  out_plain;
  } out_item_t;

endpackage

[hw/rtl/elg_mulmod.sv]
// ----------------------------------------------------------------------------
// elg_mulmod: bit-serial modular multiplier
// Interleaved shift-add: one bit of operand A per cycle, MSB first,
// accumulator kept below the modulus. Operand B must be below the modulus.
// ----------------------------------------------------------------------------
module elg_mulmod #(
  parameter int unsigned MOD_WIDTH = elg_pkg::MOD_WIDTH_DEF,
  parameter int unsigned SER_WIDTH = elg_pkg::FIELD_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [SER_WIDTH-1:0] op_a_i,
  input  logic [MOD_WIDTH-1:0] op_b_i,
  input  logic [MOD_WIDTH-1:0] modulus_i,
  output logic                 done_o,
  output logic [MOD_WIDTH-1:0] product_o
);

  localparam int unsigned CNT_W = $clog2(SER_WIDTH + 1);
  localparam int unsigned ACC_W = MOD_WIDTH + 2;

  logic                 busy_q, done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [SER_WIDTH-1:0] a_q;
  logic [MOD_WIDTH-1:0] b_q, m_q, acc_q, acc_d;

  logic [ACC_W-1:0] sum, m1, m2;

  // acc*2 + bit*b < 3m, so at most 2m comes off
  always_comb begin
    m1  = ACC_W'(m_q);
    m2  = ACC_W'({m_q, 1'b0});
    sum = ACC_W'({acc_q, 1'b0}) + (a_q[SER_WIDTH-1] ? ACC_W'(b_q) : '0);
    if (sum >= m2) begin
      acc_d = MOD_WIDTH'(sum - m2);
    end else if (sum >= m1) begin
      acc_d = MOD_WIDTH'(sum - m1);
    end else begin
      acc_d = MOD_WIDTH'(sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(SER_WIDTH);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= op_a_i;
      b_q   <= op_b_i;
      m_q   <= modulus_i;
      acc_q <= '0;
    end else if (busy_q) begin
      a_q   <= {a_q[SER_WIDTH-2:0], 1'b0};
      acc_q <= acc_d;
    end
  end

  assign done_o    = done_q;
  assign product_o = acc_q;

endmodule

[hw/rtl/elg_seq.sv]
// ----------------------------------------------------------------------------
// elg_seq: operation sequencer (decrypt also reduces the key mod p-1)
// Runs base reduction, MSB-first square-and-multiply over an exponent shift
// register, and the final product, issuing one multiply at a time.
// ----------------------------------------------------------------------------
module elg_seq #(
  parameter int unsigned MOD_WIDTH = elg_pkg::MOD_WIDTH_DEF,
  parameter int unsigned SER_WIDTH = elg_pkg::FIELD_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  elg_pkg::in_item_t    cmd_i,
  output logic                 busy_o,
  input  logic [MOD_WIDTH-1:0] modulus_i,
  input  logic [MOD_WIDTH-1:0] generator_i,
  input  logic [MOD_WIDTH-1:0] key_i,
  output elg_pkg::out_item_t   result_o,
  output logic                 valid_o,
  output logic                 mul_start_o,
  output logic [SER_WIDTH-1:0] mul_a_o,
  output logic [MOD_WIDTH-1:0] mul_b_o,
  output logic [MOD_WIDTH-1:0] mul_mod_o,
  input  logic                 mul_done_i,
  input  logic [MOD_WIDTH-1:0] mul_res_i
);

  localparam int unsigned CNT_W = $clog2(SER_WIDTH + 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RED  = 6'b000010,
    ST_KEY  = 6'b000100,
    ST_SQR  = 6'b001000,
    ST_MUL  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_e;

  // encrypt runs three powers: y = g^x, a = g^k, y^k
  typedef enum logic [1:0] {
    PASS_PUB    = 2'd0,
    PASS_FIRST  = 2'd1,
    PASS_SECOND = 2'd2
  } pass_e;

  state_e               state_q, state_d;
  pass_e                pass_q, pass_d;
  logic [CNT_W-1:0]     bcnt_q, bcnt_d;
  logic                 valid_q, valid_d;
  elg_pkg::out_item_t   res_q, res_d;
  logic [SER_WIDTH-1:0] exp_q, exp_d;
  logic                 mode_q, mode_d;
  logic [elg_pkg::BYTE_WIDTH-1:0]  msg_q, msg_d;
  logic [elg_pkg::FIELD_WIDTH-1:0] k_q, k_d, cb_q, cb_d;
  logic [MOD_WIDTH-1:0] base_q, base_d, y_q, y_d, first_q, first_d;

  logic [MOD_WIDTH-1:0] one_p, pm1, one_pm1;
  logic                 pow_done, pow_go, sq_go;
  logic [MOD_WIDTH-1:0] pow_val, sq_val;
  logic [SER_WIDTH-1:0] pow_exp;

  assign one_p   = (modulus_i == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
  assign pm1     = modulus_i - MOD_WIDTH'(1);
  assign one_pm1 = (pm1 <= MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);

  always_comb begin
    state_d  = state_q;
    pass_d   = pass_q;
    bcnt_d   = bcnt_q;
    valid_d  = 1'b0;
    res_d    = res_q;
    exp_d    = exp_q;
    mode_d   = mode_q;
    msg_d    = msg_q;
    k_d      = k_q;
    cb_d     = cb_q;
    base_d   = base_q;
    y_d      = y_q;
    first_d  = first_q;
    mul_start_o = 1'b0;
    mul_a_o     = '0;
    mul_b_o     = one_p;
    mul_mod_o   = modulus_i;
    pow_done = 1'b0;
    pow_val  = '0;
    pow_go   = 1'b0;
    pow_exp  = '0;
    sq_go    = 1'b0;
    sq_val   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          mode_d = cmd_i.mode;
          msg_d  = cmd_i.message_byte;
          k_d    = cmd_i.nonce;
          cb_d   = cmd_i.cipher_second;
          if (cmd_i.mode == elg_pkg::MODE_ENCRYPT) begin
            if (cmd_i.message_byte != '0) begin
              mul_start_o = 1'b1;
              mul_a_o     = SER_WIDTH'(generator_i);
              state_d     = ST_RED;
            end
          end else if (cmd_i.cipher_first != '0 && cmd_i.cipher_second != '0) begin
            mul_start_o = 1'b1;
            mul_a_o     = SER_WIDTH'(cmd_i.cipher_first);
            state_d     = ST_RED;
          end
        end
      end
      ST_RED: begin
        if (mul_done_i) begin
          base_d = mul_res_i;
          if (mode_q == elg_pkg::MODE_ENCRYPT) begin
            pass_d  = PASS_PUB;
            pow_go  = 1'b1;
            pow_exp = SER_WIDTH'(key_i);
          end else begin
            // x mod (p-1) for the decrypt exponent
            mul_start_o = 1'b1;
            mul_a_o     = SER_WIDTH'(key_i);
            mul_b_o     = one_pm1;
            mul_mod_o   = pm1;
            state_d     = ST_KEY;
          end
        end
      end
      ST_KEY: begin
        if (mul_done_i) begin
          pow_go  = 1'b1;
          pow_exp = SER_WIDTH'(pm1 - mul_res_i);
        end
      end
      ST_SQR: begin
        if (mul_done_i) begin
          if (exp_q[SER_WIDTH-1]) begin
            mul_start_o = 1'b1;
            mul_a_o     = SER_WIDTH'(mul_res_i);
            mul_b_o     = base_q;
            state_d     = ST_MUL;
          end else begin
            exp_d  = {exp_q[SER_WIDTH-2:0], 1'b0};
            bcnt_d = bcnt_q - CNT_W'(1);
            if (bcnt_q == CNT_W'(1)) begin
              pow_done = 1'b1;
              pow_val  = mul_res_i;
            end else begin
              sq_go  = 1'b1;
              sq_val = mul_res_i;
            end
          end
        end
      end
      ST_MUL: begin
        if (mul_done_i) begin
          exp_d  = {exp_q[SER_WIDTH-2:0], 1'b0};
          bcnt_d = bcnt_q - CNT_W'(1);
          if (bcnt_q == CNT_W'(1)) begin
            pow_done = 1'b1;
            pow_val  = mul_res_i;
          end else begin
            sq_go   = 1'b1;
            sq_val  = mul_res_i;
            state_d = ST_SQR;
          end
        end
      end
      ST_FIN: begin
        if (mul_done_i) begin
          valid_d = 1'b1;
          state_d = ST_IDLE;
          if (mode_q == elg_pkg::MODE_ENCRYPT) begin
            res_d.result_mode = elg_pkg::MODE_ENCRYPT;
            res_d.out_first   = elg_pkg::FIELD_WIDTH'(first_q);
            res_d.out_second  = elg_pkg::FIELD_WIDTH'(mul_res_i);
            res_d.out_plain   = '0;
          end else begin
            res_d.result_mode = elg_pkg::MODE_DECRYPT;
            res_d.out_first   = '0;
            res_d.out_second  = '0;
            res_d.out_plain   = elg_pkg::BYTE_WIDTH'(mul_res_i);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // end of one power: pick the next one or the final product
    if (pow_done) begin
      if (mode_q == elg_pkg::MODE_ENCRYPT) begin
        case (pass_q)
          PASS_PUB: begin
            y_d     = pow_val;
            pass_d  = PASS_FIRST;
            pow_go  = 1'b1;
            pow_exp = SER_WIDTH'(k_q);
          end
          PASS_FIRST: begin
            first_d = pow_val;
            base_d  = y_q;
            pass_d  = PASS_SECOND;
            pow_go  = 1'b1;
            pow_exp = SER_WIDTH'(k_q);
          end
          default: begin
            mul_start_o = 1'b1;
            mul_a_o     = SER_WIDTH'(msg_q);
            mul_b_o     = pow_val;
            state_d     = ST_FIN;
          end
        endcase
      end else begin
        mul_start_o = 1'b1;
        mul_a_o     = SER_WIDTH'(cb_q);
        mul_b_o     = pow_val;
        state_d     = ST_FIN;
      end
    end

    if (pow_go) begin
      exp_d   = pow_exp;
      bcnt_d  = CNT_W'(SER_WIDTH);
      state_d = ST_SQR;
      sq_go   = 1'b1;
      sq_val  = one_p;
    end

    if (sq_go) begin
      mul_start_o = 1'b1;
      mul_a_o     = SER_WIDTH'(sq_val);
      mul_b_o     = sq_val;
      mul_mod_o   = modulus_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pass_q  <= PASS_PUB;
      bcnt_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      bcnt_q  <= bcnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    exp_q   <= exp_d;
    mode_q  <= mode_d;
    msg_q   <= msg_d;
    k_q     <= k_d;
    cb_q    <= cb_d;
    base_q  <= base_d;
    y_q     <= y_d;
    first_q <= first_d;
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

[hw/rtl/elgamal_byte_cipher_top.sv]
// ----------------------------------------------------------------------------
// elgamal_byte_cipher_top: ElGamal byte encrypt / decrypt over a small prime
// Work: every modular multiply runs on the bit-serial multiplier; with
//   S = max(MOD_WIDTH, 16), encrypt takes (2 + 3*S + ones(x) + 2*ones(k))
//   multiplies and decrypt takes (3 + S + ones(e)) multiplies.
// Throughput: one item at a time; busy is high until the result strobe.
// Reset: asynchronous, active low; registers return to p=593, g=123, x=8.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module elgamal_byte_cipher_top #(
  parameter int unsigned MOD_WIDTH = elg_pkg::MOD_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // APB configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [elg_pkg::ADDR_WIDTH-1:0]      paddr,
  input  logic [elg_pkg::DATA_WIDTH-1:0]      pwdata,
  output logic [elg_pkg::DATA_WIDTH-1:0]      prdata,
  output logic                                pready,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  elg_pkg::in_item_t                   cmd_i,
  // result channel
  output logic                                out_valid_o,
  output elg_pkg::out_item_t                  result_o
);

  // serial operand and exponent length: wide enough for the modulus and for
  // the 16-bit nonce and ciphertext fields
  localparam int unsigned SER_WIDTH =
    (MOD_WIDTH > elg_pkg::FIELD_WIDTH) ? MOD_WIDTH : elg_pkg::FIELD_WIDTH;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [elg_pkg::CFG_WIDTH-1:0] prime_q, gen_q, key_q;
  logic [elg_pkg::IDX_WIDTH-1:0] reg_idx;
  logic                          wr_en;

  assign reg_idx = paddr[elg_pkg::ADDR_WIDTH-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_q <= elg_pkg::PRIME_MODULUS_RST;
      gen_q   <= elg_pkg::GENERATOR_RST;
      key_q   <= elg_pkg::PRIVATE_KEY_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        elg_pkg::REG_PRIME_MODULUS: prime_q <= pwdata[elg_pkg::CFG_WIDTH-1:0];
        elg_pkg::REG_GENERATOR:     gen_q   <= pwdata[elg_pkg::CFG_WIDTH-1:0];
        elg_pkg::REG_PRIVATE_KEY:   key_q   <= pwdata[elg_pkg::CFG_WIDTH-1:0];
        default: ;  // unmapped address: write ignored
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      elg_pkg::REG_PRIME_MODULUS: prdata = elg_pkg::DATA_WIDTH'(prime_q);
      elg_pkg::REG_GENERATOR:     prdata = elg_pkg::DATA_WIDTH'(gen_q);
      elg_pkg::REG_PRIVATE_KEY:   prdata = elg_pkg::DATA_WIDTH'(key_q);
      default:                    prdata = '0;
    endcase
  end

  // register values taken in their low MOD_WIDTH bits; p below two acts as 1
  logic [MOD_WIDTH-1:0] p_w, p_eff, g_w, x_w;

  assign p_w   = MOD_WIDTH'(prime_q);
  assign p_eff = (p_w < MOD_WIDTH'(2)) ? MOD_WIDTH'(1) : p_w;
  assign g_w   = MOD_WIDTH'(gen_q);
  assign x_w   = MOD_WIDTH'(key_q);

  // --------------------------------------------------------------------------
  // Sequencer and the shared bit-serial multiplier
  // --------------------------------------------------------------------------
  logic                 mul_start, mul_done;
  logic [SER_WIDTH-1:0] mul_a;
  logic [MOD_WIDTH-1:0] mul_b, mul_mod, mul_res;

  elg_seq #(
    .MOD_WIDTH (MOD_WIDTH),
    .SER_WIDTH (SER_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .cmd_i       (cmd_i),
    .busy_o      (busy),
    .modulus_i   (p_eff),
    .generator_i (g_w),
    .key_i       (x_w),
    .result_o    (result_o),
    .valid_o     (out_valid_o),
    .mul_start_o (mul_start),
    .mul_a_o     (mul_a),
    .mul_b_o     (mul_b),
    .mul_mod_o   (mul_mod),
    .mul_done_i  (mul_done),
    .mul_res_i   (mul_res)
  );

  elg_mulmod #(
    .MOD_WIDTH (MOD_WIDTH),
    .SER_WIDTH (SER_WIDTH)
  ) u_mulmod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .op_a_i    (mul_a),
    .op_b_i    (mul_b),
    .modulus_i (mul_mod),
    .done_o    (mul_done),
    .product_o (mul_res)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // a result strobe only ends a busy stretch
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(busy))
    else $error("result strobe without preceding work");

  // a valid encrypt transfer always starts work
  a_encrypt_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i.mode == elg_pkg::MODE_ENCRYPT &&
     cmd_i.message_byte != '0) |=> busy)
    else $error("encrypt transfer accepted but no work started");

  // ciphertext parts are reduced below the effective modulus
  a_cipher_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_o.result_mode == elg_pkg::MODE_ENCRYPT) |->
      (32'(result_o.out_first) < 32'(p_eff) && 32'(result_o.out_second) < 32'(p_eff)))
    else $error("ciphertext part not below modulus");

endmodule
